// ===== rtl/point_frustum_clip_test_core_defines.svh =====
// Assertion macros for the checker of the frustum clip test core.
`ifndef POINT_FRUSTUM_CLIP_TEST_CORE_DEFINES_SVH
`define POINT_FRUSTUM_CLIP_TEST_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define PFCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PFCT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfct_pkg.sv =====
// Types and constants of the frustum clip test core.
`timescale 1ns / 1ps
package pfct_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_W     = 64;
	localparam int IDX_W     = 8;   // config index port width
	localparam int REG_SEL_W = $clog2(NUM_REGS);
	localparam int COEF_W    = 32;
	localparam int NUM_COEF  = 16;
	localparam int PROD_W    = 2 * COEF_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int ROW_W     = PROD_W + 2;
	localparam int CMP_W     = ROW_W + 1;
	localparam int FRAC_W    = 16;

	// Config register indexes
	localparam logic [REG_SEL_W-1:0] REG_COL0_ROWS01 = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_COL0_ROWS23 = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_COL1_ROWS01 = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_COL1_ROWS23 = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_COL2_ROWS01 = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_COL2_ROWS23 = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_COL3_ROWS01 = 3'd6;
	localparam logic [REG_SEL_W-1:0] REG_COL3_ROWS23 = 3'd7;

	// Reset contents: identity matrix in Q16.16
	localparam logic [REG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
	localparam logic [REG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

	typedef logic signed [COEF_W-1:0] pfct_coef_t;
	typedef pfct_coef_t [NUM_COEF-1:0] pfct_mat_t;

	typedef struct packed {
		logic [15:0]        entry_index;
		logic               visible;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pfct_in_t;

	typedef struct packed {
		logic [15:0] result_index;
		logic        inside_res;
	} pfct_out_t;

	// Clip-space coordinates handed from the transform to the compare stage
	typedef struct packed {
		logic                    valid;
		logic [15:0]             index;
		logic                    visible;
		logic signed [ROW_W-1:0] cx;
		logic signed [ROW_W-1:0] cy;
		logic signed [ROW_W-1:0] cz;
		logic signed [ROW_W-1:0] cw;
	} pfct_clip_t;

endpackage

// ===== rtl/pfct_mat_regs.sv =====
// Matrix configuration registers, two Q16.16 coefficients per register.
`timescale 1ns / 1ps
module pfct_mat_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pfct_pkg::IDX_W-1:0] cfg_index,
	input  logic [pfct_pkg::REG_W-1:0] cfg_data,
	output pfct_pkg::pfct_mat_t       mat
);
	import pfct_pkg::*;

	logic [REG_W-1:0] regs_q [NUM_REGS];
	logic             wr_en;
	logic [REG_SEL_W-1:0] wr_sel;

	assign cfg_ready = 1'b1;
	assign wr_sel    = cfg_index[REG_SEL_W-1:0];
	// indexes beyond the list are dropped
	assign wr_en     = cfg_valid && (cfg_index[IDX_W-1:REG_SEL_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_COL0_ROWS01] <= ONE_LO;
			regs_q[REG_COL0_ROWS23] <= '0;
			regs_q[REG_COL1_ROWS01] <= ONE_HI;
			regs_q[REG_COL1_ROWS23] <= '0;
			regs_q[REG_COL2_ROWS01] <= '0;
			regs_q[REG_COL2_ROWS23] <= ONE_LO;
			regs_q[REG_COL3_ROWS01] <= '0;
			regs_q[REG_COL3_ROWS23] <= ONE_HI;
		end else if (wr_en) begin
			regs_q[wr_sel] <= cfg_data;
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_REGS; k++) begin
			mat[2*k]   = regs_q[k][COEF_W-1:0];
			mat[2*k+1] = regs_q[k][REG_W-1:COEF_W];
		end
	end

endmodule

// ===== rtl/pfct_xform.sv =====
// Pipelined 4x4 matrix by point transform: multiply, pair add, row add.
`timescale 1ns / 1ps
module pfct_xform (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  pfct_pkg::pfct_in_t   item,
	input  pfct_pkg::pfct_mat_t  mat,
	output pfct_pkg::pfct_clip_t clip
);
	import pfct_pkg::*;

	logic                     valid_s1, valid_s2, valid_s3;
	logic [15:0]              index_s1, index_s2, index_s3;
	logic                     vis_s1, vis_s2, vis_s3;
	logic signed [PROD_W-1:0] prod_s1 [4][3];
	logic signed [PAIR_W-1:0] pair_a_s2 [4];
	logic signed [PAIR_W-1:0] pair_b_s2 [4];
	logic signed [ROW_W-1:0]  row_s3 [4];
	logic signed [PAIR_W-1:0] cterm [4];

	// column 3 times w = 1.0 is a plain shift
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			cterm[r] = {{(PAIR_W-COEF_W-FRAC_W){mat[12+r][COEF_W-1]}}, mat[12+r],
				{FRAC_W{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		index_s1 <= item.entry_index;
		vis_s1   <= item.visible;
		for (int r = 0; r < 4; r++) begin
			prod_s1[r][0] <= $signed(mat[r])   * item.pos_x;
			prod_s1[r][1] <= $signed(mat[4+r]) * item.pos_y;
			prod_s1[r][2] <= $signed(mat[8+r]) * item.pos_z;
		end

		index_s2 <= index_s1;
		vis_s2   <= vis_s1;
		for (int r = 0; r < 4; r++) begin
			pair_a_s2[r] <= PAIR_W'(prod_s1[r][0]) + PAIR_W'(prod_s1[r][1]);
			pair_b_s2[r] <= PAIR_W'(prod_s1[r][2]) + cterm[r];
		end

		index_s3 <= index_s2;
		vis_s3   <= vis_s2;
		for (int r = 0; r < 4; r++) begin
			row_s3[r] <= ROW_W'(pair_a_s2[r]) + ROW_W'(pair_b_s2[r]);
		end
	end

	assign clip.valid   = valid_s3;
	assign clip.index   = index_s3;
	assign clip.visible = vis_s3;
	assign clip.cx      = row_s3[0];
	assign clip.cy      = row_s3[1];
	assign clip.cz      = row_s3[2];
	assign clip.cw      = row_s3[3];

endmodule

// ===== rtl/pfct_cmp.sv =====
// Clip-space bounds compare and result register.
`timescale 1ns / 1ps
module pfct_cmp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfct_pkg::pfct_clip_t clip,
	output logic                 result_valid,
	output pfct_pkg::pfct_out_t  result
);
	import pfct_pkg::*;

	logic signed [CMP_W-1:0] x_lo, x_hi, y_lo, y_hi, z_hi;
	logic                    w_pos, in_box;
	logic                    valid_s4;
	logic [15:0]             index_s4;
	logic                    inside_s4;

	// -w <= c  <=>  c + w >= 0 ; c <= w  <=>  w - c >= 0
	always_comb begin
		x_lo   = CMP_W'(clip.cx) + CMP_W'(clip.cw);
		x_hi   = CMP_W'(clip.cw) - CMP_W'(clip.cx);
		y_lo   = CMP_W'(clip.cy) + CMP_W'(clip.cw);
		y_hi   = CMP_W'(clip.cw) - CMP_W'(clip.cy);
		z_hi   = CMP_W'(clip.cw) - CMP_W'(clip.cz);
		w_pos  = !clip.cw[ROW_W-1] && (clip.cw != '0);
		in_box = clip.visible && w_pos && !x_lo[CMP_W-1] && !x_hi[CMP_W-1]
			&& !y_lo[CMP_W-1] && !y_hi[CMP_W-1] && !clip.cz[ROW_W-1]
			&& !z_hi[CMP_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= clip.valid;
		end
	end

	always_ff @(posedge clk) begin
		index_s4  <= clip.index;
		inside_s4 <= in_box;
	end

	assign result_valid        = valid_s4;
	assign result.result_index = index_s4;
	assign result.inside_res   = inside_s4;

endmodule

// ===== rtl/point_frustum_clip_test_core.sv =====
// Top level of the point-in-frustum clip test.
`timescale 1ns / 1ps
// Usage:
//  - An entry (index, visible flag, Q16.16 position) transfers at a rising edge
//    with start high and busy low. busy is never raised: one entry per cycle,
//    back to back, indefinitely.
//  - Each entry yields one result: result_valid is high for exactly one cycle,
//    once the entry has passed the multiply, pair add, row add and result
//    registers. Results leave in entry order.
//  - The pipeline is multiply (twelve 32x32 products), pair add, row add,
//    then bounds compare; the multiplier stage sets the cycle budget.
//  - Matrix registers are written on the cfg channel (cfg_ready is always
//    high); write only while no entries are in flight. Unknown indexes are
//    ignored.
//  - arst_n low clears the pipeline valid bits and loads the identity matrix.
//  - The receiver cannot stall: a result must be taken in its strobe cycle.
module point_frustum_clip_test_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  pfct_pkg::pfct_in_t         item,
	output logic                       result_valid,
	output pfct_pkg::pfct_out_t        result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pfct_pkg::IDX_W-1:0] cfg_index,
	input  logic [pfct_pkg::REG_W-1:0] cfg_data
);
	import pfct_pkg::*;

	pfct_mat_t  mat;
	pfct_clip_t clip;
	logic       in_valid;

	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	pfct_mat_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mat       (mat)
	);

	pfct_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.mat      (mat),
		.clip     (clip)
	);

	pfct_cmp u_cmp (
		.clk          (clk),
		.arst_n       (arst_n),
		.clip         (clip),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== rtl/pfct_checker.sv =====
// Port-level checker for the frustum clip test core, with its bind.
`timescale 1ns / 1ps
`include "point_frustum_clip_test_core_defines.svh"
module pfct_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input pfct_pkg::pfct_in_t  item,
	input logic                result_valid,
	input pfct_pkg::pfct_out_t result
);
	import pfct_pkg::*;

	`PFCT_ASSERT(a_result_follows, (start && !busy) |-> ##4 result_valid, "missing result")
	`PFCT_ASSERT(a_no_spurious,
		result_valid |-> $past(start && !busy, 4),
		"result without transfer")
	`PFCT_ASSERT(a_index_kept,
		(start && !busy) |-> ##4 (result.result_index == $past(item.entry_index, 4)),
		"index mismatch")
	`PFCT_ASSERT(a_hidden_out,
		(start && !busy && !item.visible) |-> ##4 !result.inside_res,
		"hidden entry reported inside")
	// reset clears the strobe, whatever it held before
	`PFCT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !result_valid, "strobe during reset")

endmodule

bind point_frustum_clip_test_core pfct_checker u_pfct_checker (.*);
